// ===== rtl/quadratic_bezier_tessellator_defines.svh =====
// Assertion macros for the quadratic Bezier tessellator checker.
// No dependencies; each macro expects clk and rst_n in scope.
`ifndef QUADRATIC_BEZIER_TESSELLATOR_DEFINES_SVH
`define QUADRATIC_BEZIER_TESSELLATOR_DEFINES_SVH

// Same-cycle implication.
`define QBT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QBT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/qbt_pkg.sv =====
// Shared constants, register codes and pipeline payload types of the
// quadratic Bezier tessellator. No dependencies.
package qbt_pkg;

  localparam int MAX_SEGMENTS = 128;
  localparam int COORD_WIDTH  = 21;
  localparam int POINT_W      = 3 * COORD_WIDTH;
  localparam int CNT_W        = 8;
  localparam int IDX_W        = 7;
  localparam int FRAC_W       = 16;
  localparam int ONE_Q16      = 65536;
  localparam int OFF_W        = 17;
  localparam int COMP_W       = 18;
  localparam int Q_W          = 17;
  localparam int CFG_IDX_W    = 3;
  localparam int DIV_W        = 24;
  localparam int DIV_STEP     = 4;
  localparam int DIV_STAGES   = DIV_W / DIV_STEP;
  localparam int WGT_W        = 33;
  localparam int PROD_W       = WGT_W + COORD_WIDTH;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_POINT   = 3'd0,
    REG_CONTROL_POINT = 3'd1,
    REG_END_POINT     = 3'd2,
    REG_SEGMENT_TOTAL = 3'd3,
    REG_SEGMENT_OFF   = 3'd4,
    REG_COMPLETENESS  = 3'd5,
    REG_SCALE_COUNT   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  seg_total;
    logic [OFF_W-1:0]  offset;
    logic [COMP_W-1:0] completeness;
    logic              scale;
  } cfg_t;

  typedef struct packed {
    logic [POINT_W-1:0] p0;
    logic [POINT_W-1:0] p1;
    logic [POINT_W-1:0] p2;
  } pts_t;

  typedef struct packed {
    logic [CNT_W-1:0] act;
    logic [Q_W-1:0]   lo;
    logic             ok;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [DIV_W-1:0] n;
  } front_out_t;

  typedef struct packed {
    side_t            side;
    logic [DIV_W-1:0] q;
  } div_out_t;

  // Coordinate lane k, offset by half range so it blends as unsigned.
  function automatic logic [COORD_WIDTH-1:0] lane_biased(
    input logic [POINT_W-1:0] pt, input int k);
    logic [COORD_WIDTH-1:0] raw;
    raw = pt[k*COORD_WIDTH +: COORD_WIDTH];
    return raw ^ {1'b1, {(COORD_WIDTH-1){1'b0}}};
  endfunction

endpackage

// ===== rtl/qbt_if.sv =====
// Valid/ready channel interfaces of the tessellator.
// Depends on qbt_pkg.
interface qbt_in_if;
  logic                          valid;
  logic                          ready;
  logic [qbt_pkg::IDX_W-1:0]     point_index;
  modport source (output valid, output point_index, input ready);
  modport sink (input valid, input point_index, output ready);
endinterface

interface qbt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [qbt_pkg::COORD_WIDTH-1:0] point_x;
  logic signed [qbt_pkg::COORD_WIDTH-1:0] point_y;
  logic signed [qbt_pkg::COORD_WIDTH-1:0] point_z;
  logic [qbt_pkg::CNT_W-1:0]           active_count;
  logic                                point_valid;
  modport source (output valid, output point_x, output point_y, output point_z,
                  output active_count, output point_valid, input ready);
  modport sink (input valid, input point_x, input point_y, input point_z,
                input active_count, input point_valid, output ready);
endinterface

// ===== rtl/qbt_front.sv =====
// Front stage: active segment count, validity and the scaled dividend.
// Depends on qbt_pkg.
module qbt_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [qbt_pkg::IDX_W-1:0] in_index,
  input  qbt_pkg::cfg_t             cfg,
  output logic                      out_valid,
  input  logic                      out_ready,
  output qbt_pkg::front_out_t       out_data
);

  logic                       v_r;
  qbt_pkg::front_out_t        data_r, data_nxt;
  logic                       gt_one;
  logic [qbt_pkg::Q_W-1:0]    f, lo;
  logic [25:0]                act_prod;
  logic [qbt_pkg::CNT_W-1:0]  act;
  logic [qbt_pkg::DIV_W-1:0]  base;
  logic [40:0]                num;

  always_comb begin
    gt_one   = cfg.completeness > qbt_pkg::COMP_W'(qbt_pkg::ONE_Q16);
    f        = gt_one ? qbt_pkg::Q_W'(qbt_pkg::COMP_W'(2 * qbt_pkg::ONE_Q16) - cfg.completeness)
                      : cfg.completeness[qbt_pkg::Q_W-1:0];
    lo       = gt_one ? qbt_pkg::Q_W'(cfg.completeness - qbt_pkg::COMP_W'(qbt_pkg::ONE_Q16))
                      : '0;
    act_prod = 26'({cfg.seg_total, 1'b1}) * 26'(f);
    act      = cfg.scale ? act_prod[24:17] : cfg.seg_total;
    base     = qbt_pkg::DIV_W'({in_index, 16'h0000}) + qbt_pkg::DIV_W'(cfg.offset);
    num      = 41'(base) * 41'(f);
    data_nxt.side.act = act;
    data_nxt.side.lo  = lo;
    data_nxt.side.ok  = (act > 8'd1) && ({1'b0, in_index} < act);
    data_nxt.n        = num[39:16];
  end

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/qbt_div.sv =====
// Pipelined restoring divider: sample position over active count,
// four quotient bits per stage. Depends on qbt_pkg.
module qbt_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  qbt_pkg::front_out_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output qbt_pkg::div_out_t   out_data
);

  localparam int LAST = qbt_pkg::DIV_STAGES - 1;

  logic [qbt_pkg::DIV_STAGES-1:0] v_r, adv;
  logic [qbt_pkg::DIV_W-1:0]      n_r [qbt_pkg::DIV_STAGES];
  logic [qbt_pkg::DIV_W-1:0]      q_r [qbt_pkg::DIV_STAGES];
  logic [qbt_pkg::CNT_W-1:0]      rem_r [qbt_pkg::DIV_STAGES];
  qbt_pkg::side_t                 side_r [qbt_pkg::DIV_STAGES];

  for (genvar s = 0; s < qbt_pkg::DIV_STAGES; s++) begin : g_st
    logic                      src_v;
    logic [qbt_pkg::DIV_W-1:0] src_n, src_q, n_nxt, q_nxt;
    logic [qbt_pkg::CNT_W-1:0] src_rem, rem_nxt;
    qbt_pkg::side_t            src_side;

    if (s == 0) begin : g_src0
      assign src_v    = in_valid;
      assign src_n    = in_data.n;
      assign src_q    = '0;
      assign src_rem  = '0;
      assign src_side = in_data.side;
    end else begin : g_srcn
      assign src_v    = v_r[s-1];
      assign src_n    = n_r[s-1];
      assign src_q    = q_r[s-1];
      assign src_rem  = rem_r[s-1];
      assign src_side = side_r[s-1];
    end

    if (s == LAST) begin : g_advl
      assign adv[s] = !v_r[s] || out_ready;
    end else begin : g_advn
      assign adv[s] = !v_r[s] || adv[s+1];
    end

    always_comb begin : p_step
      logic [qbt_pkg::CNT_W:0] trial;
      n_nxt   = src_n;
      q_nxt   = src_q;
      rem_nxt = src_rem;
      for (int b = 0; b < qbt_pkg::DIV_STEP; b++) begin
        trial = {rem_nxt, n_nxt[qbt_pkg::DIV_W-1]};
        n_nxt = {n_nxt[qbt_pkg::DIV_W-2:0], 1'b0};
        if (trial >= {1'b0, src_side.act}) begin
          rem_nxt = qbt_pkg::CNT_W'(trial - {1'b0, src_side.act});
          q_nxt   = {q_nxt[qbt_pkg::DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[qbt_pkg::CNT_W-1:0];
          q_nxt   = {q_nxt[qbt_pkg::DIV_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (adv[s]) begin
        v_r[s] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s] && src_v) begin
        n_r[s]    <= n_nxt;
        q_r[s]    <= q_nxt;
        rem_r[s]  <= rem_nxt;
        side_r[s] <= src_side;
      end
    end
  end

  assign in_ready      = adv[0];
  assign out_valid     = v_r[LAST];
  assign out_data.side = side_r[LAST];
  assign out_data.q    = q_r[LAST];

endmodule

// ===== rtl/qbt_blend.sv =====
// Blend pipeline: Bernstein weights, per-lane products, rounded sum.
// Depends on qbt_pkg.
module qbt_blend (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qbt_pkg::div_out_t in_data,
  input  qbt_pkg::pts_t     pts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [qbt_pkg::COORD_WIDTH-1:0] out_x,
  output logic signed [qbt_pkg::COORD_WIDTH-1:0] out_y,
  output logic signed [qbt_pkg::COORD_WIDTH-1:0] out_z,
  output logic [qbt_pkg::CNT_W-1:0]              out_count,
  output logic                                   out_ok
);

  localparam int CW = qbt_pkg::COORD_WIDTH;

  logic [2:0] v_r, adv;

  // weight stage
  logic [qbt_pkg::WGT_W-1:0]  w0_r, w1_r, w2_r;
  logic [qbt_pkg::CNT_W-1:0]  act_w_r, act_p_r;
  logic                       ok_w_r, ok_p_r;
  logic [qbt_pkg::DIV_W:0]    lsum;
  logic [qbt_pkg::Q_W-1:0]    l_pos, u_pos;
  logic [qbt_pkg::WGT_W-1:0]  uu, ul, ll;

  // product stage
  logic [qbt_pkg::PROD_W-1:0] prod_r [3][3];

  // output stage
  logic [CW-1:0]              res_nxt [3];
  logic [CW-1:0]              res_r [3];
  logic [qbt_pkg::CNT_W-1:0]  act_o_r;
  logic                       ok_o_r;

  assign adv[2]   = !v_r[2] || out_ready;
  assign adv[1]   = !v_r[1] || adv[2];
  assign adv[0]   = !v_r[0] || adv[1];
  assign in_ready = adv[0];

  always_comb begin
    lsum  = (qbt_pkg::DIV_W+1)'(in_data.side.lo) + (qbt_pkg::DIV_W+1)'(in_data.q);
    l_pos = (lsum > (qbt_pkg::DIV_W+1)'(qbt_pkg::ONE_Q16)) ? qbt_pkg::Q_W'(qbt_pkg::ONE_Q16)
                                                         : lsum[qbt_pkg::Q_W-1:0];
    u_pos = qbt_pkg::Q_W'(qbt_pkg::ONE_Q16) - l_pos;
    uu    = qbt_pkg::WGT_W'(u_pos) * qbt_pkg::WGT_W'(u_pos);
    ul    = qbt_pkg::WGT_W'(u_pos) * qbt_pkg::WGT_W'(l_pos);
    ll    = qbt_pkg::WGT_W'(l_pos) * qbt_pkg::WGT_W'(l_pos);
  end

  always_comb begin
    logic [qbt_pkg::PROD_W-1:0] s;
    for (int k = 0; k < 3; k++) begin
      s = prod_r[k][0] + prod_r[k][1] + prod_r[k][2]
        + qbt_pkg::PROD_W'(64'h8000_0000);
      res_nxt[k] = s[32 +: CW] ^ {1'b1, {(CW-1){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      if (adv[1]) v_r[1] <= v_r[0];
      if (adv[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      w0_r    <= uu;
      w1_r    <= {ul[qbt_pkg::WGT_W-2:0], 1'b0};
      w2_r    <= ll;
      act_w_r <= in_data.side.act;
      ok_w_r  <= in_data.side.ok;
    end
    if (adv[1] && v_r[0]) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k][0] <= qbt_pkg::PROD_W'(w0_r)
                      * qbt_pkg::PROD_W'(qbt_pkg::lane_biased(pts.p0, k));
        prod_r[k][1] <= qbt_pkg::PROD_W'(w1_r)
                      * qbt_pkg::PROD_W'(qbt_pkg::lane_biased(pts.p1, k));
        prod_r[k][2] <= qbt_pkg::PROD_W'(w2_r)
                      * qbt_pkg::PROD_W'(qbt_pkg::lane_biased(pts.p2, k));
      end
      act_p_r <= act_w_r;
      ok_p_r  <= ok_w_r;
    end
    if (adv[2] && v_r[1]) begin
      for (int k = 0; k < 3; k++) begin
        res_r[k] <= ok_p_r ? res_nxt[k] : '0;
      end
      act_o_r <= act_p_r;
      ok_o_r  <= ok_p_r;
    end
  end

  assign out_valid = v_r[2];
  assign out_x     = res_r[0];
  assign out_y     = res_r[1];
  assign out_z     = res_r[2];
  assign out_count = act_o_r;
  assign out_ok    = ok_o_r;

endmodule

// ===== rtl/quadratic_bezier_tessellator.sv =====
// Top level of the quadratic Bezier tessellator: configuration registers
// and the front, divide and blend pipeline. Depends on qbt_pkg, qbt_if.
//
// One point request enters per cycle unless the pipeline is stalled; its word
// passes a front register for the segment count and dividend, the divider
// stages (four quotient bits a stage) and weight, product and rounded-sum registers.
// Throughput is one word per cycle; a stalled output holds the pipeline only
// as far as full stages reach, bubbles are squeezed out. Configuration is
// sampled as a word passes, so write it while the pipeline is empty.
module quadratic_bezier_tessellator (
  input  logic                          clk,
  input  logic                          rst_n,
  qbt_in_if.sink                        in_chan,
  qbt_out_if.source                     out_chan,
  input  logic                          cfg_wen,
  input  logic [qbt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qbt_pkg::POINT_W-1:0]   cfg_wdata
);

  qbt_pkg::cfg_t       cfg_r;
  qbt_pkg::pts_t       pts_r;
  qbt_pkg::front_out_t fr_data;
  qbt_pkg::div_out_t   dv_data;
  logic                fr_valid, fr_ready, dv_valid, dv_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_r              <= '0;
      cfg_r.seg_total    <= qbt_pkg::CNT_W'(24);
      cfg_r.offset       <= '0;
      cfg_r.completeness <= qbt_pkg::COMP_W'(qbt_pkg::ONE_Q16);
      cfg_r.scale        <= 1'b1;
    end else if (cfg_wen) begin
      case (cfg_index)
        qbt_pkg::REG_START_POINT:   pts_r.p0 <= cfg_wdata;
        qbt_pkg::REG_CONTROL_POINT: pts_r.p1 <= cfg_wdata;
        qbt_pkg::REG_END_POINT:     pts_r.p2 <= cfg_wdata;
        qbt_pkg::REG_SEGMENT_TOTAL: begin
          if (cfg_wdata == '0) begin
            cfg_r.seg_total <= qbt_pkg::CNT_W'(1);
          end else if (cfg_wdata > qbt_pkg::POINT_W'(qbt_pkg::MAX_SEGMENTS)) begin
            cfg_r.seg_total <= qbt_pkg::CNT_W'(qbt_pkg::MAX_SEGMENTS);
          end else begin
            cfg_r.seg_total <= cfg_wdata[qbt_pkg::CNT_W-1:0];
          end
        end
        qbt_pkg::REG_SEGMENT_OFF: begin
          cfg_r.offset <= (cfg_wdata > qbt_pkg::POINT_W'(qbt_pkg::ONE_Q16))
                        ? qbt_pkg::OFF_W'(qbt_pkg::ONE_Q16) : cfg_wdata[qbt_pkg::OFF_W-1:0];
        end
        qbt_pkg::REG_COMPLETENESS: begin
          cfg_r.completeness <= (cfg_wdata > qbt_pkg::POINT_W'(2 * qbt_pkg::ONE_Q16))
                              ? qbt_pkg::COMP_W'(2 * qbt_pkg::ONE_Q16)
                              : cfg_wdata[qbt_pkg::COMP_W-1:0];
        end
        qbt_pkg::REG_SCALE_COUNT:   cfg_r.scale <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  qbt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_index  (in_chan.point_index),
    .cfg       (cfg_r),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_data  (fr_data)
  );

  qbt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_data),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_data  (dv_data)
  );

  qbt_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_data   (dv_data),
    .pts       (pts_r),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_x     (out_chan.point_x),
    .out_y     (out_chan.point_y),
    .out_z     (out_chan.point_z),
    .out_count (out_chan.active_count),
    .out_ok    (out_chan.point_valid)
  );

endmodule

// ===== rtl/qbt_checker.sv =====
// Port-level checks for the tessellator, bound to the top level.
// Depends on qbt_pkg and quadratic_bezier_tessellator_defines.svh.
`include "quadratic_bezier_tessellator_defines.svh"

module qbt_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [qbt_pkg::COORD_WIDTH-1:0] out_point_x,
  input logic signed [qbt_pkg::COORD_WIDTH-1:0] out_point_y,
  input logic signed [qbt_pkg::COORD_WIDTH-1:0] out_point_z,
  input logic [qbt_pkg::CNT_W-1:0]              out_active_count,
  input logic                                   out_point_valid
);

  `QBT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_point_x) && $stable(out_point_y) && $stable(out_point_z) && $stable(out_active_count) && $stable(out_point_valid), "stalled output word changed")
  `QBT_ASSERT_NOW(a_valid_count, out_valid && out_point_valid, out_active_count > 8'd1, "valid point with active count below two")
  `QBT_ASSERT_NOW(a_invalid_zero, out_valid && !out_point_valid, out_point_x == 0 && out_point_y == 0 && out_point_z == 0, "invalid point carries nonzero coordinates")
  `QBT_ASSERT_NOW(a_no_block, !in_ready, out_valid, "input blocked while output is empty")

endmodule

bind quadratic_bezier_tessellator qbt_checker u_qbt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_point_x      (out_chan.point_x),
  .out_point_y      (out_chan.point_y),
  .out_point_z      (out_chan.point_z),
  .out_active_count (out_chan.active_count),
  .out_point_valid  (out_chan.point_valid)
);

// ===== tb/tb_quadratic_bezier_tessellator.sv =====
// Self-checking testbench for quadratic_bezier_tessellator: random and directed
// point requests, curve-point prediction and word-by-word compare.
// Depends on qbt_pkg, qbt_if and the tessellator RTL.
`timescale 1ns / 1ps

module tb_quadratic_bezier_tessellator;

  localparam logic [qbt_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 5000;
  localparam int PIPE_DRAIN = 20;
  localparam logic [qbt_pkg::COORD_WIDTH-1:0] SIGN_BIT =
    {1'b1, {(qbt_pkg::COORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [qbt_pkg::COORD_WIDTH-1:0] x;
    logic [qbt_pkg::COORD_WIDTH-1:0] y;
    logic [qbt_pkg::COORD_WIDTH-1:0] z;
    logic [qbt_pkg::CNT_W-1:0]       act;
    logic                            ok;
  } curve_point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wen = 1'b0;
  logic [qbt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [qbt_pkg::POINT_W-1:0] cfg_wdata = '0;

  qbt_in_if  in_chan();
  qbt_out_if out_chan();

  quadratic_bezier_tessellator dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the register file
  logic [63:0] pt_start, pt_ctrl, pt_end;
  logic [63:0] seg_total, seg_off, comp, scale_cnt;

  curve_point_t expected_points[$];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int idle_cycles = 0;
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  int rx_hold = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] seg_count();
    logic [63:0] f;
    f = (comp > qbt_pkg::ONE_Q16) ? (2 * qbt_pkg::ONE_Q16 - comp) : comp;
    if (scale_cnt[0]) return ((2 * seg_total + 1) * f) >> 17;
    return seg_total;
  endfunction

  function automatic curve_point_t eval_curve_point(logic [qbt_pkg::IDX_W-1:0] idx);
    curve_point_t p;
    logic [63:0] f, lo, act, t, u, w0, w1, w2, s, r, a, b, c;
    logic [qbt_pkg::COORD_WIDTH-1:0] lanes[3];
    lo = (comp > qbt_pkg::ONE_Q16) ? (comp - qbt_pkg::ONE_Q16) : 64'd0;
    f = (comp > qbt_pkg::ONE_Q16) ? (2 * qbt_pkg::ONE_Q16 - comp) : comp;
    act = seg_count();
    p = '0;
    p.act = act[qbt_pkg::CNT_W-1:0];
    if (act <= 1 || 64'(idx) >= act) return p;
    t = lo + (((64'(idx) << 16) + seg_off) * f) / (act << 16);
    if (t > qbt_pkg::ONE_Q16) t = 64'(qbt_pkg::ONE_Q16);
    u = qbt_pkg::ONE_Q16 - t;
    w0 = u * u;
    w1 = 2 * u * t;
    w2 = t * t;
    for (int k = 0; k < 3; k++) begin
      a = 64'(pt_start[k*qbt_pkg::COORD_WIDTH +: qbt_pkg::COORD_WIDTH] ^ SIGN_BIT);
      b = 64'(pt_ctrl[k*qbt_pkg::COORD_WIDTH +: qbt_pkg::COORD_WIDTH] ^ SIGN_BIT);
      c = 64'(pt_end[k*qbt_pkg::COORD_WIDTH +: qbt_pkg::COORD_WIDTH] ^ SIGN_BIT);
      s = w0 * a + w1 * b + w2 * c;
      r = (s + (64'd1 << 31)) >> 32;
      lanes[k] = r[qbt_pkg::COORD_WIDTH-1:0] ^ SIGN_BIT;
    end
    p.x = lanes[0];
    p.y = lanes[1];
    p.z = lanes[2];
    p.ok = 1'b1;
    return p;
  endfunction

  task automatic write_reg(logic [qbt_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[qbt_pkg::POINT_W-1:0];
    @(negedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      qbt_pkg::REG_START_POINT:   pt_start = val & ((64'd1 << 63) - 1);
      qbt_pkg::REG_CONTROL_POINT: pt_ctrl = val & ((64'd1 << 63) - 1);
      qbt_pkg::REG_END_POINT:     pt_end = val & ((64'd1 << 63) - 1);
      qbt_pkg::REG_SEGMENT_TOTAL:
        seg_total = (val < 1) ? 64'd1 : (val > qbt_pkg::MAX_SEGMENTS)
                  ? 64'(qbt_pkg::MAX_SEGMENTS) : val;
      qbt_pkg::REG_SEGMENT_OFF:
        seg_off = (val > qbt_pkg::ONE_Q16) ? 64'(qbt_pkg::ONE_Q16) : val;
      qbt_pkg::REG_COMPLETENESS:
        comp = (val > 2 * qbt_pkg::ONE_Q16) ? 64'(2 * qbt_pkg::ONE_Q16) : val;
      qbt_pkg::REG_SCALE_COUNT:   scale_cnt = val & 64'd1;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // leaves valid high after the accepting edge
  task automatic send_point(logic [qbt_pkg::IDX_W-1:0] idx);
    @(negedge clk);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.point_index <= idx;
    do @(posedge clk); while (!in_chan.ready);
    expected_points.push_back(eval_curve_point(idx));
    words_in++;
  endtask

  function automatic logic [63:0] rand_point();
    return {$urandom, $urandom} & ((64'd1 << 63) - 1);
  endfunction

  function automatic logic [qbt_pkg::IDX_W-1:0] rand_index();
    logic [63:0] act;
    act = seg_count();
    if ($urandom_range(0, 4) == 0 || act == 0)
      return qbt_pkg::IDX_W'($urandom_range(0, 127));
    return qbt_pkg::IDX_W'($urandom_range(0, (act > 127) ? 127 : 32'(act)));
  endfunction

  task automatic randomize_regs();
    write_reg(qbt_pkg::REG_START_POINT, rand_point());
    write_reg(qbt_pkg::REG_CONTROL_POINT, rand_point());
    write_reg(qbt_pkg::REG_END_POINT, rand_point());
    write_reg(qbt_pkg::REG_SEGMENT_TOTAL,
              64'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(2, 40)));
    write_reg(qbt_pkg::REG_SEGMENT_OFF, 64'($urandom_range(0, 70000)));
    write_reg(qbt_pkg::REG_COMPLETENESS, 64'($urandom_range(0, 140000)));
    write_reg(qbt_pkg::REG_SCALE_COUNT, 64'($urandom_range(0, 1)));
  endtask

  task automatic test_reset_values();
    send_point(0);
    send_point(1);
    send_point(23);
    send_point(24);
    send_point(127);
    wait_drained();
  endtask

  task automatic test_extremes();
    // max positive / min negative / minus one coordinates
    write_reg(qbt_pkg::REG_START_POINT, {1'b0, {3{1'b0, {20{1'b1}}}}});
    write_reg(qbt_pkg::REG_CONTROL_POINT, {1'b0, {3{1'b1, 20'd0}}});
    write_reg(qbt_pkg::REG_END_POINT, 64'h7FFF_FFFF_FFFF_FFFF);
    write_reg(qbt_pkg::REG_SCALE_COUNT, 64'd0);
    write_reg(qbt_pkg::REG_SEGMENT_TOTAL, 64'd255);    // saturates to max
    write_reg(qbt_pkg::REG_SEGMENT_OFF, 64'd100000);   // saturates to one
    send_point(0);
    send_point(127);
    send_point(64);
    wait_drained();
    write_reg(qbt_pkg::REG_SEGMENT_TOTAL, 64'd0);      // count of one: invalid
    write_reg(REG_UNUSED, 64'h5);                      // ignored
    send_point(0);
    send_point(5);
    wait_drained();
    write_reg(qbt_pkg::REG_SCALE_COUNT, 64'd1);
    write_reg(qbt_pkg::REG_SEGMENT_TOTAL, 64'd128);
    write_reg(qbt_pkg::REG_SEGMENT_OFF, 64'd0);
    write_reg(qbt_pkg::REG_COMPLETENESS, 64'd0);       // nothing visible
    send_point(0);
    send_point(3);
    wait_drained();
    write_reg(qbt_pkg::REG_COMPLETENESS, 64'd200000);  // saturates to two
    send_point(0);
    wait_drained();
    write_reg(qbt_pkg::REG_COMPLETENESS, 64'd98304);   // grow-out window
    send_point(0);
    send_point(10);
    send_point(63);
    send_point(64);
    wait_drained();
    write_reg(qbt_pkg::REG_SEGMENT_OFF, 64'd65536);
    write_reg(qbt_pkg::REG_COMPLETENESS, 64'd32768);
    send_point(0);
    send_point(31);
    send_point(32);
    wait_drained();
  endtask

  task automatic test_random_phases(int phases, int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      randomize_regs();
      for (int i = 0; i < per_phase; i++) send_point(rand_index());
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    randomize_regs();
    write_reg(qbt_pkg::REG_COMPLETENESS, 64'(qbt_pkg::ONE_Q16));
    write_reg(qbt_pkg::REG_SEGMENT_TOTAL, 64'd64);
    rx_hold = 300;
    for (int i = 0; i < 40; i++) send_point(rand_index());
    // sender stops until every word is back, then resumes
    wait_drained();
    for (int i = 0; i < 20; i++) send_point(rand_index());
    wait_drained();
  endtask

  always @(negedge clk) begin : rx_ready_gen
    static int burst = 0;
    if (rx_hold > 0) begin
      out_chan.ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else if (burst > 0) begin
      out_chan.ready <= 1'b0;
      burst = burst - 1;
    end else begin
      out_chan.ready <= 1'b1;
      if (rx_gaps && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 19);
    end
  end

  always @(posedge clk) begin : check_words
    curve_point_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      words_out++;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected word x=%0d act=%0d", $time, out_chan.point_x,
                 out_chan.active_count);
        errors++;
      end else begin
        want = expected_points.pop_front();
        if (out_chan.point_x !== want.x || out_chan.point_y !== want.y ||
            out_chan.point_z !== want.z || out_chan.active_count !== want.act ||
            out_chan.point_valid !== want.ok) begin
          $display("%0t: mismatch expected x=%h y=%h z=%h act=%0d ok=%b", $time,
                   want.x, want.y, want.z, want.act, want.ok);
          $display("%0t:          actual   x=%h y=%h z=%h act=%0d ok=%b", $time,
                   out_chan.point_x, out_chan.point_y, out_chan.point_z,
                   out_chan.active_count, out_chan.point_valid);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    in_chan.valid = 1'b0;
    in_chan.point_index = '0;
    out_chan.ready = 1'b0;
    pt_start = 0;
    pt_ctrl = 0;
    pt_end = 0;
    seg_total = 24;
    seg_off = 0;
    comp = qbt_pkg::ONE_Q16;
    scale_cnt = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_extremes();
    test_random_phases(8, 50);
    test_backpressure();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    test_random_phases(2, 40);

    $display("Covered %0d point requests, %0d words checked, over directed corners,",
             words_in, words_out);
    $display("random register settings, a long output stall and gap-free streaming.");
    if (errors == 0 && expected_points.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
